[hw/rtl/rvdec_pkg.sv]
// Package for the RV64I decoder: mnemonic codes, opcodes, decode function
// and the search token passed along the label cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rvdec_pkg;

    localparam int MAX_LABELS_DEF = 16;
    localparam int LBL_NUM_W      = 9;

    localparam logic [6:0] OP_R    = 7'b0110011;
    localparam logic [6:0] OP_IALU = 7'b0010011;
    localparam logic [6:0] OP_LOAD = 7'b0000011;
    localparam logic [6:0] OP_JALR = 7'b1100111;
    localparam logic [6:0] OP_S    = 7'b0100011;
    localparam logic [6:0] OP_B    = 7'b1100011;
    localparam logic [6:0] OP_J    = 7'b1101111;
    localparam logic [6:0] OP_LUI  = 7'b0110111;

    localparam logic [5:0] MN_NONE = 6'd0;
    localparam logic [5:0] MN_ADD = 6'd1, MN_SUB = 6'd2, MN_XOR = 6'd3, MN_OR = 6'd4;
    localparam logic [5:0] MN_AND = 6'd5, MN_SLL = 6'd6, MN_SRL = 6'd7, MN_SRA = 6'd8;
    localparam logic [5:0] MN_SLT = 6'd9, MN_SLTU = 6'd10;
    localparam logic [5:0] MN_ADDI = 6'd11, MN_XORI = 6'd12, MN_ORI = 6'd13;
    localparam logic [5:0] MN_ANDI = 6'd14, MN_SLTI = 6'd15, MN_SLTIU = 6'd16;
    localparam logic [5:0] MN_SLLI = 6'd17, MN_SRLI = 6'd18, MN_SRAI = 6'd19;
    localparam logic [5:0] MN_LB = 6'd20, MN_LH = 6'd21, MN_LW = 6'd22, MN_LD = 6'd23;
    localparam logic [5:0] MN_LBU = 6'd24, MN_LHU = 6'd25, MN_LWU = 6'd26;
    localparam logic [5:0] MN_JALR = 6'd27;
    localparam logic [5:0] MN_SB = 6'd28, MN_SH = 6'd29, MN_SW = 6'd30, MN_SD = 6'd31;
    localparam logic [5:0] MN_BEQ = 6'd32, MN_BNE = 6'd33, MN_BLT = 6'd34;
    localparam logic [5:0] MN_BGE = 6'd35, MN_BLTU = 6'd36, MN_BGEU = 6'd37;
    localparam logic [5:0] MN_JAL = 6'd38, MN_LUI = 6'd39;

    typedef struct packed {
        logic [5:0]  mnemonic;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [20:0] immediate;
        logic        need_lbl;
    } dec_t;

    typedef struct packed {
        logic                 active;
        logic                 need_lbl;
        logic [31:0]          here_addr;
        logic [31:0]          tgt_addr;
        logic [LBL_NUM_W-1:0] here_num;
        logic [LBL_NUM_W-1:0] ref_num;
    } srch_t;

    function automatic dec_t decode(input logic [31:0] w);
        dec_t       d;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [20:0] imm_i;
        f3    = w[14:12];
        f7    = w[31:25];
        imm_i = {{9{w[31]}}, w[31:20]};
        d = '0;
        case (w[6:0])
            OP_R:
            begin
                d.rd = w[11:7]; d.rs1 = w[19:15]; d.rs2 = w[24:20];
                if (f7 == 7'd0)
                begin
                    case (f3)
                        3'd0: d.mnemonic = MN_ADD;
                        3'd1: d.mnemonic = MN_SLL;
                        3'd2: d.mnemonic = MN_SLT;
                        3'd3: d.mnemonic = MN_SLTU;
                        3'd4: d.mnemonic = MN_XOR;
                        3'd5: d.mnemonic = MN_SRL;
                        3'd6: d.mnemonic = MN_OR;
                        default: d.mnemonic = MN_AND;
                    endcase
                end
                else if (f7 == 7'd32)
                begin
                    case (f3)
                        3'd0: d.mnemonic = MN_SUB;
                        3'd5: d.mnemonic = MN_SRA;
                        default: d.mnemonic = MN_NONE;
                    endcase
                end
            end
            OP_IALU:
            begin
                d.rd = w[11:7]; d.rs1 = w[19:15];
                case (f3)
                    3'd1:
                    begin
                        d.immediate = {15'd0, w[25:20]};
                        d.mnemonic  = (w[31:26] == 6'd0) ? MN_SLLI : MN_NONE;
                    end
                    3'd5:
                    begin
                        d.immediate = {15'd0, w[25:20]};
                        d.mnemonic  = (w[31:26] == 6'd0) ? MN_SRLI :
                                      (w[31:26] == 6'd16) ? MN_SRAI : MN_NONE;
                    end
                    3'd0: begin d.immediate = imm_i; d.mnemonic = MN_ADDI; end
                    3'd2: begin d.immediate = imm_i; d.mnemonic = MN_SLTI; end
                    3'd3: begin d.immediate = imm_i; d.mnemonic = MN_SLTIU; end
                    3'd4: begin d.immediate = imm_i; d.mnemonic = MN_XORI; end
                    3'd6: begin d.immediate = imm_i; d.mnemonic = MN_ORI; end
                    default: begin d.immediate = imm_i; d.mnemonic = MN_ANDI; end
                endcase
            end
            OP_LOAD:
            begin
                d.rd = w[11:7]; d.rs1 = w[19:15]; d.immediate = imm_i;
                case (f3)
                    3'd0: d.mnemonic = MN_LB;
                    3'd1: d.mnemonic = MN_LH;
                    3'd2: d.mnemonic = MN_LW;
                    3'd3: d.mnemonic = MN_LD;
                    3'd4: d.mnemonic = MN_LBU;
                    3'd5: d.mnemonic = MN_LHU;
                    3'd6: d.mnemonic = MN_LWU;
                    default: d.mnemonic = MN_NONE;
                endcase
            end
            OP_JALR:
            begin
                d.rd = w[11:7]; d.rs1 = w[19:15]; d.immediate = imm_i;
                d.mnemonic = (f3 == 3'd0) ? MN_JALR : MN_NONE;
            end
            OP_S:
            begin
                d.rs1 = w[19:15]; d.rs2 = w[24:20];
                d.immediate = {{9{w[31]}}, w[31:25], w[11:7]};
                case (f3)
                    3'd0: d.mnemonic = MN_SB;
                    3'd1: d.mnemonic = MN_SH;
                    3'd2: d.mnemonic = MN_SW;
                    3'd3: d.mnemonic = MN_SD;
                    default: d.mnemonic = MN_NONE;
                endcase
            end
            OP_B:
            begin
                d.rs1 = w[19:15]; d.rs2 = w[24:20];
                d.immediate = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    3'd0: d.mnemonic = MN_BEQ;
                    3'd1: d.mnemonic = MN_BNE;
                    3'd4: d.mnemonic = MN_BLT;
                    3'd5: d.mnemonic = MN_BGE;
                    3'd6: d.mnemonic = MN_BLTU;
                    3'd7: d.mnemonic = MN_BGEU;
                    default: d.mnemonic = MN_NONE;
                endcase
                d.need_lbl = 1'b1;
            end
            OP_J:
            begin
                d.rd = w[11:7];
                d.immediate = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                d.mnemonic = MN_JAL;
                d.need_lbl = 1'b1;
            end
            OP_LUI:
            begin
                d.rd = w[11:7];
                d.immediate = {1'b0, w[31:12]};
                d.mnemonic = MN_LUI;
            end
            default: d = '0;
        endcase
        if (d.mnemonic == MN_NONE)
        begin
            d = '0;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/rvdec_if.sv]
// Handshake interfaces for the instruction and result channels.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface rvdec_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;
    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvdec_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  mnemonic;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic signed [20:0] immediate;
    logic [4:0]  label_ref;
    logic [4:0]  label_here;
    logic        table_full;
    modport source (output valid, output mnemonic, output rd, output rs1, output rs2,
                    output immediate, output label_ref, output label_here,
                    output table_full, input ready);
    modport sink   (input valid, input mnemonic, input rd, input rs1, input rs2,
                    input immediate, input label_ref, input label_here,
                    input table_full, output ready);
endinterface
`default_nettype wire

[hw/rtl/rv64i_decoder_with_branch_labels.sv]
// RV64I decoder top level: decode, label cell chain and result register.
// Depends on rvdec_pkg, rvdec_if and rvdec_cell.
// One instruction at a time: decode on acceptance, then a search token walks
// the chain of MAX_LABELS label cells, one cell per cycle while the result is
// not stalled, matching both the branch target and the current address; the
// result is registered as the token leaves the last cell, and the next
// instruction is taken only after that. Label numbers are given in order of
// first target appearance; table_full flags a target that found no free cell.
// Instruction n sits at byte address 4n.
`timescale 1ns / 1ps
`default_nettype none
module rv64i_decoder_with_branch_labels #(
    parameter int MAX_LABELS = rvdec_pkg::MAX_LABELS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rvdec_in_if.sink    instr,
    rvdec_out_if.source result
);
    localparam int CW = $clog2(MAX_LABELS + 1);
    localparam int NW = rvdec_pkg::LBL_NUM_W;

    logic [31:0]      addr_reg;
    logic [CW-1:0]    count_reg;
    logic             busy_reg;
    rvdec_pkg::dec_t  dec_reg;
    rvdec_pkg::dec_t  dec_in;
    rvdec_pkg::srch_t chain [0:MAX_LABELS];

    logic             out_valid_reg;
    logic [5:0]       mn_reg;
    logic [4:0]       rd_reg, rs1_reg, rs2_reg, ref_reg, here_reg;
    logic [20:0]      imm_reg;
    logic             full_reg;

    logic             accept, stall, en, finish, add_lbl, full_now;
    logic [NW-1:0]    ref_num;
    logic [NW-1:0]    count_ext;

    assign dec_in    = rvdec_pkg::decode(instr.instr_word);
    assign instr.ready = !busy_reg;
    assign accept    = instr.valid && !busy_reg;
    assign stall     = chain[MAX_LABELS].active && out_valid_reg && !result.ready;
    assign en        = !stall;
    assign finish    = chain[MAX_LABELS].active && en;
    assign count_ext = NW'(count_reg);

    assign chain[0] = '{active:    accept,
                        need_lbl:  dec_in.need_lbl,
                        here_addr: addr_reg,
                        tgt_addr:  addr_reg + {{11{dec_in.immediate[20]}}, dec_in.immediate},
                        here_num:  '0,
                        ref_num:   '0};

    assign add_lbl  = dec_reg.need_lbl && chain[MAX_LABELS].ref_num == '0
                      && count_reg < CW'(MAX_LABELS);
    assign full_now = dec_reg.need_lbl && chain[MAX_LABELS].ref_num == '0
                      && !(count_reg < CW'(MAX_LABELS));
    assign ref_num  = add_lbl ? count_ext + NW'(1) :
                      dec_reg.need_lbl ? chain[MAX_LABELS].ref_num : '0;

    for (genvar i = 0; i < MAX_LABELS; i++)
    begin : g_cell
        rvdec_cell #(.IDX(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .count   (count_ext),
            .wr_en   (finish && add_lbl),
            .wr_idx  (count_ext),
            .wr_data (chain[MAX_LABELS].tgt_addr),
            .s_in    (chain[i]),
            .s_out   (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                addr_reg <= addr_reg + 32'd4;
            end
            if (finish)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                if (add_lbl)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dec_reg <= dec_in;
        end
        if (finish)
        begin
            mn_reg   <= dec_reg.mnemonic;
            rd_reg   <= dec_reg.rd;
            rs1_reg  <= dec_reg.rs1;
            rs2_reg  <= dec_reg.rs2;
            imm_reg  <= dec_reg.immediate;
            ref_reg  <= ref_num[4:0];
            here_reg <= chain[MAX_LABELS].here_num[4:0];
            full_reg <= full_now;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.mnemonic   = mn_reg;
    assign result.rd         = rd_reg;
    assign result.rs1        = rs1_reg;
    assign result.rs2        = rs2_reg;
    assign result.immediate  = imm_reg;
    assign result.label_ref  = ref_reg;
    assign result.label_here = here_reg;
    assign result.table_full = full_reg;
endmodule
`default_nettype wire

[hw/rtl/rvdec_cell.sv]
// One label cell: holds a target address and checks the passing search token.
// Depends on rvdec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rvdec_cell #(
    parameter int IDX = 0
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic [rvdec_pkg::LBL_NUM_W-1:0] count,
    input  wire logic                           wr_en,
    input  wire logic [rvdec_pkg::LBL_NUM_W-1:0] wr_idx,
    input  wire logic [31:0]                    wr_data,
    input  wire rvdec_pkg::srch_t               s_in,
    output rvdec_pkg::srch_t                    s_out
);
    localparam logic [rvdec_pkg::LBL_NUM_W-1:0] MY_IDX = rvdec_pkg::LBL_NUM_W'(IDX);
    localparam logic [rvdec_pkg::LBL_NUM_W-1:0] MY_NUM = rvdec_pkg::LBL_NUM_W'(IDX + 1);

    logic [31:0]      target_reg;
    rvdec_pkg::srch_t s_reg;
    rvdec_pkg::srch_t s_next;
    logic             live;

    assign live = MY_IDX < count;

    always_comb
    begin
        s_next = s_in;
        if (live && s_in.here_num == '0 && target_reg == s_in.here_addr)
        begin
            s_next.here_num = MY_NUM;
        end
        if (live && s_in.ref_num == '0 && target_reg == s_in.tgt_addr)
        begin
            s_next.ref_num = MY_NUM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= '0;
        end
        else if (en)
        begin
            s_reg <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_idx == MY_IDX)
        begin
            target_reg <= wr_data;
        end
    end

    assign s_out = s_reg;
endmodule
`default_nettype wire

[hw/rtl/rvdec_checker.sv]
// Port-level checks for the RV64I decoder, bound to the top level.
// Depends on rvdec_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module rvdec_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [5:0]  mnemonic,
    input wire logic [4:0]  rd,
    input wire logic [4:0]  rs1,
    input wire logic [4:0]  rs2,
    input wire logic [20:0] immediate,
    input wire logic [4:0]  label_ref,
    input wire logic        table_full
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mnemonic))
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    a_unknown_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mnemonic == rvdec_pkg::MN_NONE |->
        rd == 5'd0 && rs1 == 5'd0 && rs2 == 5'd0 && immediate == 21'd0 && label_ref == 5'd0)
        else $error("unknown encoding with non-zero fields");

    a_full_no_ref: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> label_ref == 5'd0 &&
        (mnemonic == rvdec_pkg::MN_JAL || mnemonic >= rvdec_pkg::MN_BEQ))
        else $error("table full on non-branch or with label");
endmodule

bind rv64i_decoder_with_branch_labels rvdec_checker u_rvdec_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (instr.valid),
    .in_ready   (instr.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .mnemonic   (result.mnemonic),
    .rd         (result.rd),
    .rs1        (result.rs1),
    .rs2        (result.rs2),
    .immediate  (result.immediate),
    .label_ref  (result.label_ref),
    .table_full (result.table_full)
);
`default_nettype wire
